FILE: design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value table: field widths, table
// size, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package kvt_pkg;

   // Table geometry
   localparam int TableEntries = 64;
   localparam int IdxW         = $clog2(TableEntries);
   localparam int CntW         = $clog2(TableEntries + 1);

   // Field widths
   localparam int ModeW   = 2;
   localparam int KeyW    = 64;
   localparam int ValW    = 64;
   localparam int StatusW = 3;

   // Operation codes carried in the mode field
   typedef enum logic [ModeW-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_FIND   = 2'd2
   } mode_type;

   // Response status codes
   typedef enum logic [StatusW-1:0] {
      ST_NOT_FOUND = 3'd0,
      ST_FOUND     = 3'd1,
      ST_ADDED     = 3'd2,
      ST_REPLACED  = 3'd3,
      ST_REMOVED   = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_VAL_TAKE,
      S_DONE
   } state_type;

endpackage

FILE: design/kvt_if.sv
// ----------------------------------------------------------------------------
// kvt_if
// Valid/ready channels of the key/value table: request and response.
// ----------------------------------------------------------------------------

// Request channel: one table operation per request
interface kvt_req_if;
   logic                      valid;
   logic                      ready;
   logic [kvt_pkg::ModeW-1:0] mode;
   logic [kvt_pkg::KeyW-1:0]  lookup_key;
   logic [kvt_pkg::ValW-1:0]  new_value;

   modport source (output valid, output mode, output lookup_key, output new_value,
                   input ready);
   modport sink   (input valid, input mode, input lookup_key, input new_value,
                   output ready);
endinterface

// Response channel: one status word per request
interface kvt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kvt_pkg::StatusW-1:0] status;
   logic [kvt_pkg::ValW-1:0]    found_value;

   modport source (output valid, output status, output found_value, input ready);
   modport sink   (input valid, input status, input found_value, output ready);
endinterface

FILE: design/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvt_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/key_value_table_with_swap_remove.sv
// ----------------------------------------------------------------------------
// key_value_table_with_swap_remove
// Packed key/value table with linear search, append on add and swap-remove.
// ----------------------------------------------------------------------------
// Each request is one operation (add or replace, remove, find) and yields
// exactly one response. Keys and values live in two synchronous RAMs. Every
// operation scans the live entries from slot 0 upward, one key per cycle
// through the key RAM read port, and the scan stops at the first match.
// A finished response waits in an output register, so the next request can be
// taken while the previous response is still unclaimed. A new result waits in
// S_DONE for as long as the response before it stays unclaimed. Reset
// empties the table at once; there is no clearing pass, since only slots below
// the live count are ever read.
module key_value_table_with_swap_remove (
   input logic      clock,
   input logic      reset,
   kvt_req_if.sink  req,
   kvt_rsp_if.source rsp
);

   // Controller and request registers
   kvt_pkg::state_type  state_ff, state_in;
   kvt_pkg::mode_type   mode_ff, mode_in;
   logic                mode_ok_ff, mode_ok_in;
   logic [kvt_pkg::KeyW-1:0]  key_ff, key_in;
   logic [kvt_pkg::ValW-1:0]  val_ff, val_in;
   logic [kvt_pkg::CntW-1:0]  count_ff, count_in;

   // Scan pipeline: read issue index and the index being compared
   logic [kvt_pkg::CntW-1:0]  rd_idx_ff, rd_idx_in;
   logic [kvt_pkg::IdxW-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                      cmp_valid_ff, cmp_valid_in;
   logic [kvt_pkg::IdxW-1:0]  slot_ff, slot_in;

   // Pending result and output register
   kvt_pkg::status_type       res_status_ff, res_status_in;
   logic [kvt_pkg::ValW-1:0]  res_value_ff, res_value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [kvt_pkg::StatusW-1:0] rsp_status_ff, rsp_status_in;
   logic [kvt_pkg::ValW-1:0]  rsp_value_ff, rsp_value_in;

   // RAM ports
   logic                      key_we, val_we;
   logic [kvt_pkg::IdxW-1:0]  key_waddr, val_waddr, key_raddr, val_raddr;
   logic [kvt_pkg::KeyW-1:0]  key_wdata, key_rdata;
   logic [kvt_pkg::ValW-1:0]  val_wdata, val_rdata;

   logic                      req_fire;
   logic                      issue;
   logic                      hit;
   logic                      full;
   logic [kvt_pkg::CntW-1:0]  cnt_dec;

   kvt_ram #(.Width(kvt_pkg::KeyW), .Depth(kvt_pkg::TableEntries)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   kvt_ram #(.Width(kvt_pkg::ValW), .Depth(kvt_pkg::TableEntries)) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_waddr),
      .wdata (val_wdata),
      .raddr (val_raddr),
      .rdata (val_rdata)
   );

   assign req.ready = (state_ff == kvt_pkg::S_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.found_value = rsp_value_ff;

   // Scan helpers
   assign issue   = (rd_idx_ff < count_ff);
   assign hit     = cmp_valid_ff && (key_rdata == key_ff);
   assign full    = (count_ff == kvt_pkg::CntW'(kvt_pkg::TableEntries));
   assign cnt_dec = count_ff - kvt_pkg::CntW'(1);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvt_pkg::S_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      mode_ok_ff    <= mode_ok_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Next state, RAM accesses and result
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      mode_ok_in    = mode_ok_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_valid_in  = 1'b0;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      key_we    = 1'b0;
      val_we    = 1'b0;
      key_waddr = slot_ff;
      val_waddr = slot_ff;
      key_wdata = key_rdata;
      val_wdata = val_rdata;
      key_raddr = rd_idx_ff[kvt_pkg::IdxW-1:0];
      val_raddr = cmp_idx_ff;

      unique case (state_ff)
         kvt_pkg::S_IDLE: begin
            if (req_fire) begin
               key_in       = req.lookup_key;
               val_in       = req.new_value;
               rd_idx_in    = '0;
               res_value_in = '0;
               mode_ok_in   = (req.mode == kvt_pkg::MODE_ADD) ||
                              (req.mode == kvt_pkg::MODE_REMOVE) ||
                              (req.mode == kvt_pkg::MODE_FIND);
               mode_in      = kvt_pkg::mode_type'(req.mode);
               if (mode_ok_in) begin
                  state_in = kvt_pkg::S_SCAN;
               end else begin
                  // unused mode code: no change, not found
                  res_status_in = kvt_pkg::ST_NOT_FOUND;
                  state_in      = kvt_pkg::S_DONE;
               end
            end
         end

         kvt_pkg::S_SCAN: begin
            // issue one key read per cycle, compare the one read last cycle
            cmp_valid_in = issue;
            cmp_idx_in   = rd_idx_ff[kvt_pkg::IdxW-1:0];
            rd_idx_in    = rd_idx_ff + kvt_pkg::CntW'(issue);
            if (hit) begin
               cmp_valid_in = 1'b0;
               slot_in      = cmp_idx_ff;
               unique case (mode_ff)
                  kvt_pkg::MODE_ADD: begin
                     val_we        = 1'b1;
                     val_waddr     = cmp_idx_ff;
                     val_wdata     = val_ff;
                     res_status_in = kvt_pkg::ST_REPLACED;
                     state_in      = kvt_pkg::S_DONE;
                  end
                  kvt_pkg::MODE_REMOVE: begin
                     // fetch the last entry to fill the hole
                     key_raddr = cnt_dec[kvt_pkg::IdxW-1:0];
                     val_raddr = cnt_dec[kvt_pkg::IdxW-1:0];
                     state_in  = kvt_pkg::S_MOVE;
                  end
                  kvt_pkg::MODE_FIND: begin
                     val_raddr = cmp_idx_ff;
                     state_in  = kvt_pkg::S_VAL_TAKE;
                  end
                  default: begin
                     res_status_in = kvt_pkg::ST_NOT_FOUND;
                     state_in      = kvt_pkg::S_DONE;
                  end
               endcase
            end else if (!issue) begin
               // every live entry compared without a match
               cmp_valid_in = 1'b0;
               state_in     = kvt_pkg::S_DONE;
               if (mode_ff == kvt_pkg::MODE_ADD) begin
                  if (full) begin
                     res_status_in = kvt_pkg::ST_FULL;
                  end else begin
                     key_we        = 1'b1;
                     val_we        = 1'b1;
                     key_waddr     = count_ff[kvt_pkg::IdxW-1:0];
                     val_waddr     = count_ff[kvt_pkg::IdxW-1:0];
                     key_wdata     = key_ff;
                     val_wdata     = val_ff;
                     count_in      = count_ff + kvt_pkg::CntW'(1);
                     res_status_in = kvt_pkg::ST_ADDED;
                  end
               end else begin
                  res_status_in = kvt_pkg::ST_NOT_FOUND;
               end
            end
         end

         kvt_pkg::S_MOVE: begin
            // copy last entry into the matched slot, shrink the table
            key_we        = 1'b1;
            val_we        = 1'b1;
            key_waddr     = slot_ff;
            val_waddr     = slot_ff;
            key_wdata     = key_rdata;
            val_wdata     = val_rdata;
            count_in      = cnt_dec;
            res_status_in = kvt_pkg::ST_REMOVED;
            state_in      = kvt_pkg::S_DONE;
         end

         kvt_pkg::S_VAL_TAKE: begin
            res_value_in  = val_rdata;
            res_status_in = kvt_pkg::ST_FOUND;
            state_in      = kvt_pkg::S_DONE;
         end

         kvt_pkg::S_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = kvt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = kvt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: sim/key_value_table_with_swap_remove_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_with_swap_remove_tb
// Self-checking bench for the packed key/value table with swap-remove.
// ----------------------------------------------------------------------------
// Drives add, remove, find and the unused operation code over the request
// channel and keeps its own copy of the table to predict every response.
// A short directed table covers the empty table, all-zero and all-one keys,
// replace, swap-remove from the middle and from the end, and ignored fields.
// Fill bursts then push the table to full and drain it again, mixed with
// random traffic over a small key pool so that hits are common. Both sides
// idle and stall at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module key_value_table_with_swap_remove_tb;

   localparam int          CLOCK_HALF  = 4;
   localparam int          RESET_TICKS = 12;
   localparam int          RANDOM_OPS  = 750;
   localparam int          KEY_POOL    = 12;
   localparam int          REPORT_MAX  = 10;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   // Mode code the block must ignore
   localparam logic [kvt_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;

   localparam logic [kvt_pkg::KeyW-1:0] ALL_ONES = '1;
   localparam logic [kvt_pkg::KeyW-1:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [kvt_pkg::KeyW-1:0] ALT_5    = 64'h5555_5555_5555_5555;

   typedef struct {
      kvt_pkg::status_type       status;
      logic [kvt_pkg::ValW-1:0]  value;
   } table_result_type;

   typedef struct {
      logic [kvt_pkg::ModeW-1:0] op;
      logic [kvt_pkg::KeyW-1:0]  key;
      logic [kvt_pkg::ValW-1:0]  val;
      bit                        typed;
      kvt_pkg::status_type       status;
      logic [kvt_pkg::ValW-1:0]  value;
   } dir_row_type;

   localparam int DIR_ROWS = 22;

   // Directed requests; rows with typed set carry the response by hand
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{kvt_pkg::MODE_FIND,   '0,       '0,       1'b1, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_REMOVE, ALL_ONES, '0,       1'b1, kvt_pkg::ST_NOT_FOUND, '0},
      '{MODE_UNUSED,          ALL_ONES, ALL_ONES, 1'b1, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_ADD,    '0,       ALL_ONES, 1'b1, kvt_pkg::ST_ADDED,     '0},
      '{kvt_pkg::MODE_ADD,    ALL_ONES, '0,       1'b1, kvt_pkg::ST_ADDED,     '0},
      '{kvt_pkg::MODE_FIND,   '0,       '0,       1'b1, kvt_pkg::ST_FOUND,     ALL_ONES},
      '{kvt_pkg::MODE_FIND,   ALL_ONES, ALL_ONES, 1'b1, kvt_pkg::ST_FOUND,     '0},
      '{kvt_pkg::MODE_ADD,    '0,       ALT_5,    1'b1, kvt_pkg::ST_REPLACED,  '0},
      '{MODE_UNUSED,          '0,       '0,       1'b1, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_FIND,   '0,       '0,       1'b1, kvt_pkg::ST_FOUND,     ALT_5},
      '{kvt_pkg::MODE_ADD,    ALT_A,    ALT_A,    1'b1, kvt_pkg::ST_ADDED,     '0},
      '{kvt_pkg::MODE_FIND,   ALT_A,    '0,       1'b0, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_REMOVE, '0,       ALL_ONES, 1'b1, kvt_pkg::ST_REMOVED,   '0},
      '{kvt_pkg::MODE_FIND,   ALT_A,    '0,       1'b0, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_FIND,   '0,       '0,       1'b1, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_REMOVE, ALL_ONES, '0,       1'b1, kvt_pkg::ST_REMOVED,   '0},
      '{kvt_pkg::MODE_FIND,   ALL_ONES, '0,       1'b1, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_REMOVE, ALL_ONES, '0,       1'b1, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_REMOVE, ALT_A,    '0,       1'b1, kvt_pkg::ST_REMOVED,   '0},
      '{kvt_pkg::MODE_ADD,    ALT_5,    ALL_ONES, 1'b1, kvt_pkg::ST_ADDED,     '0},
      '{kvt_pkg::MODE_FIND,   ALT_5,    '0,       1'b0, kvt_pkg::ST_NOT_FOUND, '0},
      '{kvt_pkg::MODE_FIND,   '0,       ALL_ONES, 1'b1, kvt_pkg::ST_NOT_FOUND, '0}
   };

   logic clock;
   logic reset;

   kvt_req_if req_ch ();
   kvt_rsp_if rsp_ch ();

   key_value_table_with_swap_remove u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Shadow copy of the table
   logic [kvt_pkg::KeyW-1:0] model_keys   [kvt_pkg::TableEntries];
   logic [kvt_pkg::ValW-1:0] model_values [kvt_pkg::TableEntries];
   int                       model_count;

   table_result_type         pending_results [$];
   table_result_type         blank_result;
   logic [kvt_pkg::KeyW-1:0] key_pool [KEY_POOL];

   int          error_count;
   int          ops_issued;
   int          rsp_count;
   int          rsp_stall;
   int          next_stall;
   bit          calm;
   int unsigned cycle_count;

   // Clock
   initial clock = 1'b0;
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Idle or stall length for one request or response
   function automatic int pick_wait();
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   // Applies one operation to the shadow table and returns its response
   function automatic table_result_type apply_table_op(
         logic [kvt_pkg::ModeW-1:0] op,
         logic [kvt_pkg::KeyW-1:0]  key,
         logic [kvt_pkg::ValW-1:0]  val);
      table_result_type res;
      int               slot;
      res.status = kvt_pkg::ST_NOT_FOUND;
      res.value  = '0;
      slot = 0;
      while (slot < model_count && model_keys[slot] != key) slot++;
      case (op)
         kvt_pkg::MODE_ADD: begin
            if (slot < model_count) begin
               model_values[slot] = val;
               res.status = kvt_pkg::ST_REPLACED;
            end else if (model_count >= kvt_pkg::TableEntries) begin
               res.status = kvt_pkg::ST_FULL;
            end else begin
               model_keys[model_count]   = key;
               model_values[model_count] = val;
               model_count++;
               res.status = kvt_pkg::ST_ADDED;
            end
         end
         kvt_pkg::MODE_REMOVE: begin
            // swap the last live entry into the hole
            if (slot < model_count) begin
               model_keys[slot]   = model_keys[model_count-1];
               model_values[slot] = model_values[model_count-1];
               model_count--;
               res.status = kvt_pkg::ST_REMOVED;
            end
         end
         kvt_pkg::MODE_FIND: begin
            if (slot < model_count) begin
               res.value  = model_values[slot];
               res.status = kvt_pkg::ST_FOUND;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Compares one response with the oldest expectation
   function automatic void check_response(logic [kvt_pkg::StatusW-1:0] got_status,
                                          logic [kvt_pkg::ValW-1:0]    got_value);
      table_result_type want;
      if (pending_results.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("[%0t] response %0d with no request outstanding: status %0d value %h",
                     $realtime, rsp_count, got_status, got_value);
      end else begin
         want = pending_results.pop_front();
         if (got_status !== want.status || got_value !== want.value) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("[%0t] response %0d: status %0d (exp %0d), value %h (exp %h)",
                        $realtime, rsp_count, got_status, want.status,
                        got_value, want.value);
         end
      end
      rsp_count++;
   endfunction

   // Response side: check on every handshake, then stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         check_response(rsp_ch.status, rsp_ch.found_value);
         next_stall = pick_wait();
         rsp_stall    <= next_stall;
         rsp_ch.ready <= (next_stall == 0);
      end else if (rsp_stall > 1) begin
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_stall    <= 0;
         rsp_ch.ready <= 1'b1;
      end
   end

   // Sends one request; the response is predicted when it is accepted
   task automatic issue_op(input logic [kvt_pkg::ModeW-1:0] op,
                           input logic [kvt_pkg::KeyW-1:0]  key,
                           input logic [kvt_pkg::ValW-1:0]  val,
                           input bit                        typed,
                           input table_result_type          typed_res);
      int               gap;
      table_result_type res;
      gap = pick_wait();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= op;
      req_ch.lookup_key <= key;
      req_ch.new_value  <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      res = apply_table_op(op, key, val);
      pending_results.push_back(typed ? typed_res : res);
      ops_issued++;
   endtask

   // Fills the table to full, probes it, then swap-removes it back down
   task automatic fill_and_drain();
      int target;
      int k;
      while (model_count < kvt_pkg::TableEntries)
         issue_op(kvt_pkg::MODE_ADD, rand64(), rand64(), 1'b0, blank_result);
      // fresh keys are refused once full
      repeat (3) issue_op(kvt_pkg::MODE_ADD, rand64(), rand64(), 1'b0, blank_result);
      // replace still works when full
      issue_op(kvt_pkg::MODE_ADD, model_keys[$urandom_range(0, kvt_pkg::TableEntries-1)],
               rand64(), 1'b0, blank_result);
      issue_op(kvt_pkg::MODE_FIND, model_keys[0], rand64(), 1'b0, blank_result);
      issue_op(kvt_pkg::MODE_FIND, model_keys[kvt_pkg::TableEntries-1], rand64(),
               1'b0, blank_result);
      issue_op(kvt_pkg::MODE_REMOVE, model_keys[kvt_pkg::TableEntries-1], rand64(),
               1'b0, blank_result);
      target = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      while (model_count > target) begin
         k = $urandom_range(0, model_count - 1);
         if ($urandom_range(0, 3) == 0)
            issue_op(kvt_pkg::MODE_FIND, model_keys[k], rand64(), 1'b0, blank_result);
         issue_op(kvt_pkg::MODE_REMOVE, model_keys[k], rand64(), 1'b0, blank_result);
      end
   endtask

   // Stimulus
   initial begin
      table_result_type          row_res;
      logic [kvt_pkg::ModeW-1:0] op;
      logic [kvt_pkg::KeyW-1:0]  key;
      int                        pick;
      int                        len;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.mode       = kvt_pkg::MODE_FIND;
      req_ch.lookup_key = '0;
      req_ch.new_value  = '0;
      rsp_ch.ready      = 1'b0;
      calm              = 1'b0;
      model_count       = 0;
      error_count       = 0;
      ops_issued        = 0;
      rsp_count         = 0;
      blank_result.status = kvt_pkg::ST_NOT_FOUND;
      blank_result.value  = '0;

      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[i]) begin
         row_res.status = dir_rows[i].status;
         row_res.value  = dir_rows[i].value;
         issue_op(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
                  dir_rows[i].typed, row_res);
      end

      // key pool keeps hits frequent in mixed traffic
      key_pool[0] = '0;
      key_pool[1] = ALL_ONES;
      for (int p = 2; p < KEY_POOL; p++) key_pool[p] = rand64();

      ops_issued = 0;
      fill_and_drain();
      while (ops_issued < RANDOM_OPS) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0) begin
            fill_and_drain();
         end else begin
            len = $urandom_range(20, 60);
            for (int n = 0; n < len; n++) begin
               pick = $urandom_range(0, 99);
               key  = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, KEY_POOL-1)]
                                                  : rand64();
               if (pick < 35) begin
                  op = kvt_pkg::MODE_ADD;
               end else if (pick < 95) begin
                  op = (pick < 60) ? kvt_pkg::MODE_REMOVE : kvt_pkg::MODE_FIND;
                  // aim at a live entry half of the time
                  if (model_count > 0 && $urandom_range(0, 1) == 1)
                     key = model_keys[$urandom_range(0, model_count - 1)];
               end else begin
                  op = MODE_UNUSED;
               end
               issue_op(op, key, rand64(), 1'b0, blank_result);
            end
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then watch for stray responses
      while (pending_results.size() != 0) @(posedge clock);
      repeat (kvt_pkg::TableEntries + 8) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
